// ===== src/srsi_pkg.sv =====
// Shared constants and types for the sorted range index search unit.
`timescale 1ns / 1ps

package srsi_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_W       = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int PTR_W       = IDX_W + 1;
    localparam int STEP_COUNT  = IDX_W + 1;

    // Fixed field widths of the ports
    localparam int POS_W = 10;
    localparam int CNT_W = 11;
    localparam int OUT_W = 10;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Search state handed from one step cell to the next
    typedef struct packed {
        logic             valid;
        logic             pend;
        logic [PTR_W-1:0] base;
        logic [PTR_W-1:0] len;
    } t_step;

endpackage

// ===== src/srsi_cell.sv =====
// One halving step of a bound search, registered state plus compare and update.
`timescale 1ns / 1ps

module srsi_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_inclusive,
    input  logic [srsi_pkg::KEY_W-1:0] i_bound,
    input  logic [srsi_pkg::KEY_W-1:0] i_key,
    input  srsi_pkg::t_step            i_prev,
    output srsi_pkg::t_step            o_next,
    output logic [srsi_pkg::IDX_W-1:0] o_addr,
    output logic                       o_active
);

    srsi_pkg::t_step               r_step;
    logic [srsi_pkg::PTR_W-1:0]    half;
    logic [srsi_pkg::PTR_W-1:0]    mid;
    logic                          go_right;
    logic [srsi_pkg::PTR_W-1:0]    n_base;
    logic [srsi_pkg::PTR_W-1:0]    n_len;
    logic [srsi_pkg::PTR_W-1:0]    probe;

    // Take the state handed over by the previous cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step.valid <= 1'b0;
        end else begin
            r_step.valid <= i_prev.valid;
        end
        r_step.pend <= i_prev.pend;
        r_step.base <= i_prev.base;
        r_step.len  <= i_prev.len;
    end

    // Compare the probed key and keep the lower or upper part
    always_comb begin
        half     = r_step.len >> 1;
        mid      = r_step.base + half;
        go_right = i_inclusive ? (i_key <= i_bound) : (i_key < i_bound);
        n_base   = r_step.base;
        n_len    = r_step.len;
        if (r_step.pend) begin
            if (go_right) begin
                n_base = mid + srsi_pkg::PTR_W'(1);
                n_len  = r_step.len - half - srsi_pkg::PTR_W'(1);
            end else begin
                n_len  = half;
            end
        end
        probe = n_base + (n_len >> 1);
    end

    // Hand the updated state on and issue the next probe address
    assign o_next.valid = r_step.valid;
    assign o_next.pend  = (n_len != '0);
    assign o_next.base  = n_base;
    assign o_next.len   = n_len;
    assign o_addr       = r_step.valid ? probe[srsi_pkg::IDX_W-1:0] : '0;
    assign o_active     = r_step.valid;

endmodule

// ===== src/sorted_range_index_search_unit.sv =====
// Top level: key table memory, two chains of search cells, result clamp and output word.
// A query result passes the search cells of both chains, the pending result register and the output word.
// A new query is taken only after the last one has left the search cells; a table write yields no word.
// There are 11 search cells in each chain, one memory probe per cell and cycle.
// Reset (synchronous, active low) clears entry_count and all valid flags; table is not cleared.
// The input stalls while a search runs or a finished result waits behind the output word.
`timescale 1ns / 1ps

module sorted_range_index_search_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [srsi_pkg::CNT_W-1:0] i_cfg_data,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_command,
    input  logic [srsi_pkg::POS_W-1:0] i_entry_position,
    input  logic [srsi_pkg::KEY_W-1:0] i_entry_key,
    input  logic [srsi_pkg::KEY_W-1:0] i_low_bound,
    input  logic [srsi_pkg::KEY_W-1:0] i_high_bound,
    // output channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [srsi_pkg::OUT_W-1:0] o_first_index,
    output logic [srsi_pkg::OUT_W-1:0] o_last_index
);

    localparam int NC = srsi_pkg::STEP_COUNT;

    logic [srsi_pkg::KEY_W-1:0] r_mem [srsi_pkg::TABLE_DEPTH];
    logic [srsi_pkg::CNT_W-1:0] r_entry_count;
    logic [srsi_pkg::KEY_W-1:0] r_low_bound;
    logic [srsi_pkg::KEY_W-1:0] r_high_bound;
    logic [srsi_pkg::PTR_W-1:0] r_n;
    logic [srsi_pkg::KEY_W-1:0] r_rd_lo;
    logic [srsi_pkg::KEY_W-1:0] r_rd_hi;
    logic                       r_pend_valid;
    logic [srsi_pkg::IDX_W-1:0] r_pend_first;
    logic [srsi_pkg::IDX_W-1:0] r_pend_last;
    logic                       r_out_valid;
    logic [srsi_pkg::IDX_W-1:0] r_out_first;
    logic [srsi_pkg::IDX_W-1:0] r_out_last;

    srsi_pkg::t_step            chain_lo [NC+1];
    srsi_pkg::t_step            chain_hi [NC+1];
    logic [srsi_pkg::IDX_W-1:0] addr_lo  [NC];
    logic [srsi_pkg::IDX_W-1:0] addr_hi  [NC];
    logic [NC-1:0]              active_lo;
    logic [NC-1:0]              active_hi;

    logic                       busy;
    logic                       accept;
    logic                       wr_en;
    logic                       query_start;
    logic [srsi_pkg::PTR_W-1:0] n_clamped;
    logic [srsi_pkg::IDX_W-1:0] rd_addr_lo;
    logic [srsi_pkg::IDX_W-1:0] rd_addr_hi;
    logic [srsi_pkg::PTR_W-1:0] lo_res;
    logic [srsi_pkg::PTR_W-1:0] hi_res;
    logic [srsi_pkg::PTR_W-1:0] n_first;
    logic [srsi_pkg::PTR_W-1:0] n_last;
    logic                       out_load;

    // Handshake decode
    assign busy        = (|active_lo) | (|active_hi);
    assign o_stall     = busy | r_pend_valid;
    assign accept      = i_valid & ~o_stall;
    assign wr_en       = accept && (i_command == srsi_pkg::CMD_WRITE)
                         && (32'(i_entry_position) < 32'(srsi_pkg::TABLE_DEPTH));
    assign query_start = accept && (i_command == srsi_pkg::CMD_QUERY);
    assign o_cfg_ready = 1'b1;

    // Clamp the entry count to the table depth
    assign n_clamped = (32'(r_entry_count) > 32'(srsi_pkg::TABLE_DEPTH))
                       ? srsi_pkg::PTR_W'(srsi_pkg::TABLE_DEPTH)
                       : srsi_pkg::PTR_W'(r_entry_count);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_entry_count <= i_cfg_data;
        end
    end

    // Capture query bounds and count
    always_ff @(posedge i_clk) begin
        if (query_start) begin
            r_low_bound  <= i_low_bound;
            r_high_bound <= i_high_bound;
            r_n          <= n_clamped;
        end
    end

    // Feed the first cell of each chain
    always_comb begin
        chain_lo[0].valid = query_start;
        chain_lo[0].pend  = (n_clamped != '0);
        chain_lo[0].base  = '0;
        chain_lo[0].len   = n_clamped;
        chain_hi[0]       = chain_lo[0];
    end

    // Select the probe address of the running step
    always_comb begin
        rd_addr_lo = query_start ? srsi_pkg::IDX_W'(n_clamped >> 1) : '0;
        rd_addr_hi = rd_addr_lo;
        for (int k = 0; k < NC; k++) begin
            rd_addr_lo = rd_addr_lo | addr_lo[k];
            rd_addr_hi = rd_addr_hi | addr_hi[k];
        end
    end

    // Key table: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[srsi_pkg::IDX_W'(i_entry_position)] <= i_entry_key;
        end
        r_rd_lo <= r_mem[rd_addr_lo];
        r_rd_hi <= r_mem[rd_addr_hi];
    end

    // Search cells, one halving step each
    for (genvar k = 0; k < NC; k++) begin : g_cell
        srsi_cell u_lo (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_inclusive (1'b0),
            .i_bound     (r_low_bound),
            .i_key       (r_rd_lo),
            .i_prev      (chain_lo[k]),
            .o_next      (chain_lo[k+1]),
            .o_addr      (addr_lo[k]),
            .o_active    (active_lo[k])
        );
        srsi_cell u_hi (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_inclusive (1'b1),
            .i_bound     (r_high_bound),
            .i_key       (r_rd_hi),
            .i_prev      (chain_hi[k]),
            .o_next      (chain_hi[k+1]),
            .o_addr      (addr_hi[k]),
            .o_active    (active_hi[k])
        );
    end

    // Clamp both search results into the used range
    always_comb begin
        lo_res = chain_lo[NC].base;
        hi_res = chain_hi[NC].base;
        if (lo_res == '0) begin
            n_first = '0;
        end else if (lo_res >= r_n) begin
            n_first = r_n - srsi_pkg::PTR_W'(1);
        end else begin
            n_first = lo_res;
        end
        if (hi_res == '0) begin
            n_last = '0;
        end else if (hi_res >= r_n) begin
            n_last = r_n - srsi_pkg::PTR_W'(1);
        end else begin
            n_last = hi_res - srsi_pkg::PTR_W'(1);
        end
    end

    assign out_load = r_pend_valid && (!r_out_valid || !i_stall);

    // Hold the finished result until the output word is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (chain_lo[NC].valid) begin
            r_pend_valid <= 1'b1;
        end else if (out_load) begin
            r_pend_valid <= 1'b0;
        end
        if (chain_lo[NC].valid) begin
            r_pend_first <= n_first[srsi_pkg::IDX_W-1:0];
            r_pend_last  <= n_last[srsi_pkg::IDX_W-1:0];
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_first <= r_pend_first;
            r_out_last  <= r_pend_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_first_index = srsi_pkg::OUT_W'(r_out_first);
    assign o_last_index  = srsi_pkg::OUT_W'(r_out_last);

endmodule

// ===== src/srsi_checker.sv =====
// Port-level checker for the sorted range index search unit, bound to the top level.
`timescale 1ns / 1ps

module srsi_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       i_command,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [srsi_pkg::OUT_W-1:0] o_first_index,
    input logic [srsi_pkg::OUT_W-1:0] o_last_index
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_first_index) && $stable(o_last_index))
        else $error("stalled output word changed");

    // Block further words while a query searches
    a_busy_after_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_command == srsi_pkg::CMD_QUERY) |=> o_stall)
        else $error("input not stalled during search");

    // Drop no result straight after a query starts
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_command == srsi_pkg::CMD_QUERY) |=> !$rose(o_valid))
        else $error("result appeared one cycle after query accept");

    // Clear the output after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind sorted_range_index_search_unit srsi_checker u_srsi_checker (.*);
